// File: rtl/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types and constants of the two-level page table mapper.
// ----------------------------------------------------------------------------
package tlpt_pkg;

	localparam int DIR_ENTRIES   = 1024;
	localparam int TABLE_SLOTS   = 16;
	localparam int TABLE_ENTRIES = 1024;

	localparam int DIR_SHIFT = 22;
	localparam int TBL_SHIFT = 12;
	localparam int FLAG_W    = 12;
	localparam int ADDR_W    = 32;

	// directory and table indexes share one sweep counter; both depths are fixed
	localparam int IDX_W  = $clog2(DIR_ENTRIES);
	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int TBL_AW = SLOT_W + IDX_W;

	localparam logic [IDX_W-1:0] DIR_LAST = IDX_W'(DIR_ENTRIES - 1);
	localparam logic [IDX_W-1:0] TBL_LAST = IDX_W'(TABLE_ENTRIES - 1);

	typedef enum logic [1:0] {
		OP_MAP   = 2'd0,
		OP_XLATE = 2'd1,
		OP_UNMAP = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] virt_addr;
		logic [ADDR_W-1:0] phys_addr;
		logic [FLAG_W-1:0] flags;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic [ADDR_W-1:0] entry;
	} rsp_t;

	typedef struct packed {
		logic              present;
		logic [SLOT_W-1:0] slot;
		logic [FLAG_W-1:0] flags;
	} dir_ent_t;

	typedef struct packed {
		logic              alloc;
		logic              rel;
		logic [SLOT_W-1:0] rel_slot;
		logic              wipe;
	} pool_cmd_t;

	typedef struct packed {
		logic              any_free;
		logic [SLOT_W-1:0] lowest;
	} pool_sts_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DIR,
		ST_TBL,
		ST_FILL,
		ST_WIPE
	} state_t;

endpackage

// File: rtl/two_level_page_table_mapper.sv
// ----------------------------------------------------------------------------
// two_level_page_table_mapper
// Page directory and pooled page tables in synchronous memories.
// ----------------------------------------------------------------------------
// Sequence: IDLE takes a request and reads its directory entry. DIR answers
// a map or unmap, or a translate of an empty region; a translate that finds a
// table reads it and TBL answers. A map that opens a new table zeroes the slot
// in FILL first; clear sweeps the directory in WIPE. One request is handled at
// a time; the directory read precedes the table access on single-port memories.
// Reset: the directory is swept to not-present entry by entry, req_ready low.
// ----------------------------------------------------------------------------
module two_level_page_table_mapper
	import tlpt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	state_t state_q, state_d;

	op_t               op_q;
	logic [IDX_W-1:0]  dir_idx_q;
	logic [IDX_W-1:0]  tbl_idx_q;
	logic [ADDR_W-1:0] pte_q;
	logic [FLAG_W-1:0] flags_q;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic [IDX_W-1:0]  cnt_q, cnt_d;
	logic              cap;

	// directory memory
	dir_ent_t         dir_mem [DIR_ENTRIES];
	dir_ent_t         dir_rd_q;
	dir_ent_t         dir_wdata;
	logic [IDX_W-1:0] dir_addr;
	logic             dir_en, dir_we;

	// page table memory
	logic [ADDR_W-1:0] tbl_mem [TABLE_SLOTS * TABLE_ENTRIES];
	logic [ADDR_W-1:0] tbl_rd_q;
	logic [ADDR_W-1:0] tbl_wdata;
	logic [TBL_AW-1:0] tbl_addr;
	logic              tbl_en, tbl_we;

	pool_cmd_t pool_cmd;
	pool_sts_t pool_sts;

	logic rsp_valid_q;
	rsp_t rsp_q, rsp_d;
	logic rsp_load;
	logic rsp_free;

	tlpt_slot_pool u_pool (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (pool_cmd),
		.sts    (pool_sts)
	);

	assign rsp_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk) begin
		if (dir_en) begin
			if (dir_we) begin
				dir_mem[dir_addr] <= dir_wdata;
			end else begin
				dir_rd_q <= dir_mem[dir_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_en) begin
			if (tbl_we) begin
				tbl_mem[tbl_addr] <= tbl_wdata;
			end else begin
				tbl_rd_q <= tbl_mem[tbl_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			op_q      <= req.op;
			dir_idx_q <= req.virt_addr[DIR_SHIFT +: IDX_W];
			tbl_idx_q <= req.virt_addr[TBL_SHIFT +: IDX_W];
			pte_q     <= req.phys_addr | ADDR_W'(req.flags);
			flags_q   <= req.flags;
		end
		slot_q <= slot_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		slot_d    = slot_q;
		cap       = 1'b0;
		req_ready = 1'b0;
		dir_en    = 1'b0;
		dir_we    = 1'b0;
		dir_addr  = cnt_q;
		dir_wdata = '0;
		tbl_en    = 1'b0;
		tbl_we    = 1'b0;
		tbl_addr  = {slot_q, cnt_q};
		tbl_wdata = '0;
		pool_cmd  = '0;
		rsp_load  = 1'b0;
		rsp_d     = '0;

		unique case (state_q)
			ST_INIT: begin
				dir_en = 1'b1;
				dir_we = 1'b1;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == DIR_LAST) begin
					state_d = ST_IDLE;
				end
			end

			ST_IDLE: begin
				req_ready = 1'b1;
				dir_addr  = req.virt_addr[DIR_SHIFT +: IDX_W];
				if (req_valid) begin
					dir_en  = 1'b1;
					cap     = 1'b1;
					state_d = ST_DIR;
				end
			end

			ST_DIR: begin
				// hold until the result register can take this item's answer
				if (rsp_free) begin
					unique case (op_q)
						OP_MAP: begin
							priority if (dir_rd_q.present) begin
								tbl_en    = 1'b1;
								tbl_we    = 1'b1;
								tbl_addr  = {dir_rd_q.slot, tbl_idx_q};
								tbl_wdata = pte_q;
								rsp_load  = 1'b1;
								rsp_d.ok  = 1'b1;
								state_d   = ST_IDLE;
							end else if (!pool_sts.any_free) begin
								rsp_load = 1'b1;
								state_d  = ST_IDLE;
							end else begin
								pool_cmd.alloc  = 1'b1;
								dir_en          = 1'b1;
								dir_we          = 1'b1;
								dir_addr        = dir_idx_q;
								dir_wdata.present = 1'b1;
								dir_wdata.slot  = pool_sts.lowest;
								dir_wdata.flags = flags_q;
								slot_d          = pool_sts.lowest;
								cnt_d           = '0;
								state_d         = ST_FILL;
							end
						end
						OP_XLATE: begin
							if (dir_rd_q.present) begin
								tbl_en   = 1'b1;
								tbl_addr = {dir_rd_q.slot, tbl_idx_q};
								state_d  = ST_TBL;
							end else begin
								rsp_load = 1'b1;
								state_d  = ST_IDLE;
							end
						end
						OP_UNMAP: begin
							if (dir_rd_q.present) begin
								pool_cmd.rel      = 1'b1;
								pool_cmd.rel_slot = dir_rd_q.slot;
								dir_en            = 1'b1;
								dir_we            = 1'b1;
								dir_addr          = dir_idx_q;
							end
							rsp_load = 1'b1;
							rsp_d.ok = 1'b1;
							state_d  = ST_IDLE;
						end
						OP_CLEAR: begin
							pool_cmd.wipe = 1'b1;
							cnt_d         = '0;
							state_d       = ST_WIPE;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end

			ST_TBL: begin
				if (rsp_free) begin
					rsp_load    = 1'b1;
					rsp_d.ok    = 1'b1;
					rsp_d.entry = tbl_rd_q;
					state_d     = ST_IDLE;
				end
			end

			ST_FILL: begin
				// zero the new table, dropping the mapped entry in on the way
				tbl_en    = 1'b1;
				tbl_we    = 1'b1;
				tbl_wdata = (cnt_q == tbl_idx_q) ? pte_q : '0;
				if (cnt_q == TBL_LAST) begin
					if (rsp_free) begin
						rsp_load = 1'b1;
						rsp_d.ok = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end

			ST_WIPE: begin
				dir_en = 1'b1;
				dir_we = 1'b1;
				if (cnt_q == DIR_LAST) begin
					if (rsp_free) begin
						rsp_load = 1'b1;
						rsp_d.ok = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end

			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/tlpt_slot_pool.sv
// ----------------------------------------------------------------------------
// tlpt_slot_pool
// Free map of the page table slots with a lowest-free-slot search.
// ----------------------------------------------------------------------------
module tlpt_slot_pool
	import tlpt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pool_cmd_t cmd,
	output pool_sts_t sts
);

	logic [TABLE_SLOTS-1:0] free_q;
	logic [SLOT_W-1:0]      lowest;

	// scan downwards so the lowest free slot wins
	always_comb begin
		lowest = '0;
		for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				lowest = SLOT_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
		end else if (cmd.wipe) begin
			free_q <= '1;
		end else begin
			if (cmd.alloc) begin
				free_q[lowest] <= 1'b0;
			end
			if (cmd.rel) begin
				free_q[cmd.rel_slot] <= 1'b1;
			end
		end
	end

	assign sts.any_free = |free_q;
	assign sts.lowest   = lowest;

endmodule

// File: tb/tb_two_level_page_table_mapper.sv
// ----------------------------------------------------------------------------
// tb_two_level_page_table_mapper
// Self-checking bench for the two-level page table mapper. Directed requests
// cover empty regions, maps into new and existing tables, pool exhaustion,
// unmap and clear. A long random run follows, with regions drawn mostly from
// a small hot set so that tables are shared, the pool runs dry and translates
// hit mapped pages. Both handshakes idle at random, and one long response
// hold-off backs the block up. Every response is checked against a
// cycle-free model of the directory, the table pool and the free slots.
// ----------------------------------------------------------------------------
module tb_two_level_page_table_mapper
	import tlpt_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          N_RANDOM  = 1000;
	localparam int          N_HOT     = 24;
	localparam int          HOLD_LEN  = 300;
	localparam int unsigned LIMIT     = 6_000_000;

	// Cycle-free model of the mapper and the queue of responses it predicts
	class page_map_scoreboard;
		bit                dir_present [DIR_ENTRIES];
		logic [SLOT_W-1:0] dir_slot    [DIR_ENTRIES];
		bit                slot_used   [TABLE_SLOTS];
		logic [ADDR_W-1:0] page_word   [TABLE_SLOTS*TABLE_ENTRIES];
		rsp_t              pending[$];
		int                errors;
		int                requests;
		int                pool_full;
		int                xlate_hits;
		int                clears;

		function void drop_region(int d);
			if (dir_present[d]) begin
				slot_used[dir_slot[d]] = 1'b0;
				dir_present[d] = 1'b0;
				dir_slot[d] = '0;
			end
		endfunction

		function void note_request(req_t r);
			int   d;
			int   t;
			int   s;
			int   i;
			rsp_t e;
			d = int'(r.virt_addr[DIR_SHIFT +: IDX_W]);
			t = int'(r.virt_addr[TBL_SHIFT +: IDX_W]);
			e = '0;
			requests++;
			case (r.op)
				OP_MAP: begin
					e.ok = 1'b1;
					if (!dir_present[d]) begin
						s = -1;
						for (i = TABLE_SLOTS - 1; i >= 0; i--)
							if (!slot_used[i])
								s = i;
						if (s < 0) begin
							e.ok = 1'b0;
							pool_full++;
						end else begin
							slot_used[s] = 1'b1;
							dir_present[d] = 1'b1;
							dir_slot[d] = SLOT_W'(s);
							for (i = 0; i < TABLE_ENTRIES; i++)
								page_word[s*TABLE_ENTRIES + i] = '0;
						end
					end
					if (e.ok)
						page_word[int'(dir_slot[d])*TABLE_ENTRIES + t] =
							r.phys_addr | ADDR_W'(r.flags);
				end
				OP_XLATE: begin
					if (dir_present[d]) begin
						e.ok = 1'b1;
						e.entry = page_word[int'(dir_slot[d])*TABLE_ENTRIES + t];
						xlate_hits++;
					end
				end
				OP_UNMAP: begin
					drop_region(d);
					e.ok = 1'b1;
				end
				default: begin
					for (i = 0; i < DIR_ENTRIES; i++)
						drop_region(i);
					e.ok = 1'b1;
					clears++;
				end
			endcase
			pending.push_back(e);
		endfunction

		function void check_response(rsp_t r);
			rsp_t e;
			if (pending.size() == 0) begin
				$error("response with nothing outstanding: ok=%0b entry=%h",
				       r.ok, r.entry);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (r.ok !== e.ok) begin
				$error("ok: expected %0b, actual %0b", e.ok, r.ok);
				errors++;
			end
			if (r.entry !== e.entry) begin
				$error("entry: expected %h, actual %h", e.entry, r.entry);
				errors++;
			end
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	logic        idle_on  = 1'b1;
	logic        hold_req = 1'b0;
	logic        hold_done = 1'b0;
	int          hold_left = 0;
	int unsigned cycle_count = 0;

	page_map_scoreboard sb = new();
	int                 hot_dir [N_HOT];
	logic [ADDR_W-1:0]  mapped_va[$];

	two_level_page_table_mapper uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("two_level_page_table_mapper test failed");
			$finish;
		end
	end

	// Note the request before the response so a same-edge pair stays ordered
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
		end
	end

	// Response side: random back-pressure, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			rsp_ready <= 1'b0;
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else begin
			rsp_ready <= !(idle_on && $urandom_range(0, 99) < 12);
		end
	end

	function automatic req_t make_req(op_t op, logic [ADDR_W-1:0] va,
					  logic [ADDR_W-1:0] pa, logic [FLAG_W-1:0] fl);
		req_t r;
		r.op        = op;
		r.virt_addr = va;
		r.phys_addr = pa;
		r.flags     = fl;
		return r;
	endfunction

	// Called at a rising edge; returns at the edge where the transfer happens
	task automatic send_req(input req_t item);
		int gap;
		gap = 0;
		while (idle_on && $urandom_range(0, 99) < 12)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	function automatic logic [ADDR_W-1:0] pick_va(bit any_region);
		int d;
		if (any_region || $urandom_range(0, 99) < 15)
			d = $urandom_range(0, DIR_ENTRIES - 1);
		else
			d = hot_dir[$urandom_range(0, N_HOT - 1)];
		return {IDX_W'(d), 22'($urandom)};
	endfunction

	task automatic send_random();
		int                roll;
		req_t              r;
		logic [ADDR_W-1:0] va;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			// noise: every field random
			r = req_t'({$urandom, $urandom, $urandom});
		end else if (roll < 50) begin
			va = pick_va(1'b0);
			r = make_req(OP_MAP, va, $urandom, FLAG_W'($urandom));
			mapped_va.push_back(va);
			if (mapped_va.size() > 64)
				void'(mapped_va.pop_front());
		end else if (roll < 87) begin
			if (mapped_va.size() > 0 && $urandom_range(0, 99) < 60)
				va = mapped_va[$urandom_range(0, mapped_va.size() - 1)]
				     ^ ADDR_W'($urandom_range(0, 4095));
			else
				va = pick_va(1'b0);
			r = make_req(OP_XLATE, va, $urandom, FLAG_W'($urandom));
		end else if (roll < 97) begin
			r = make_req(OP_UNMAP, pick_va(1'b0), $urandom, FLAG_W'($urandom));
		end else begin
			r = make_req(OP_CLEAR, $urandom, $urandom, FLAG_W'($urandom));
		end
		send_req(r);
	endtask

	initial begin
		int i;
		hot_dir[0] = 0;
		hot_dir[1] = DIR_ENTRIES - 1;
		for (i = 2; i < N_HOT; i++)
			hot_dir[i] = $urandom_range(0, DIR_ENTRIES - 1);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty directory: translate misses, unmap is harmless
		send_req(make_req(OP_XLATE, 32'h0000_0000, 32'h0, 12'h0));
		send_req(make_req(OP_UNMAP, 32'h0000_0000, 32'h0, 12'h0));
		// all-ones entry in region 0, then a hit and an unwritten page
		send_req(make_req(OP_MAP, 32'h0000_0000, 32'hFFFF_F000, 12'hFFF));
		send_req(make_req(OP_XLATE, 32'h0000_0FFF, 32'h0, 12'h0));
		send_req(make_req(OP_XLATE, 32'h0000_1FFF, 32'hFFFF_FFFF, 12'hFFF));
		// second page into the existing table, with other flags
		send_req(make_req(OP_MAP, 32'h003F_FFFF, 32'h1234_5000, 12'h003));
		send_req(make_req(OP_XLATE, 32'h003F_F000, 32'h0, 12'h0));
		// top page of the address space, all zero
		send_req(make_req(OP_MAP, 32'hFFFF_FFFF, 32'h0, 12'h0));
		// use up the remaining slots, then one map too many
		for (i = 1; i <= TABLE_SLOTS - 2; i++)
			send_req(make_req(OP_MAP, {IDX_W'(i), 22'h0}, 32'hA000_0000 + i, 12'h001));
		send_req(make_req(OP_MAP, {IDX_W'(512), 22'h0}, 32'h5555_5000, 12'h007));
		send_req(make_req(OP_XLATE, {IDX_W'(512), 22'h0}, 32'h0, 12'h0));
		send_req(make_req(OP_UNMAP, {IDX_W'(3), 22'h3FFFFF}, 32'h0, 12'h0));
		send_req(make_req(OP_MAP, {IDX_W'(512), 22'h0}, 32'h5555_5000, 12'h007));
		send_req(make_req(OP_CLEAR, 32'h0, 32'h0, 12'h0));

		for (i = 0; i < N_RANDOM; i++) begin
			// quiet stretch on both sides, then one long response hold-off
			if (i == 400)
				idle_on <= 1'b0;
			if (i == 600)
				idle_on <= 1'b1;
			if (i == 700)
				hold_req <= 1'b1;
			send_random();
		end
		req_valid <= 1'b0;
		// let the last transfer reach the scoreboard before waiting on it
		@(posedge clk);

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d requests: %0d translate hits, %0d maps refused on a full pool,",
			 sb.requests, sb.xlate_hits, sb.pool_full);
		$display("and %0d clears, with random and long response stalls", sb.clears);
		if (sb.errors == 0)
			$display("two_level_page_table_mapper test passed");
		else
			$display("two_level_page_table_mapper test failed");
		$finish;
	end

endmodule
